// ===== sv/pct_pkg.sv =====
`timescale 1ns / 1ps

package pct_pkg;

	localparam int DEF_MAX_POINTS = 64;
	localparam int DEF_TAG_BITS   = 16;

	// fixed field widths of the ports
	localparam int POINT_W    = 6;
	localparam int TAG_PORT_W = 16;
	localparam int MASK_W     = 64;
	localparam int CFG_W      = 7;
	localparam int REQ_W      = 2;

	localparam logic [CFG_W-1:0] CFG_NUM_POINTS_RST = 7'd64;

	// request kinds
	localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
	localparam logic [REQ_W-1:0] REQ_MARK  = 2'd2;

	// pair progress codes
	localparam logic [1:0] CELL_BLANK = 2'd0;
	localparam logic [1:0] CELL_HALF  = 2'd1;
	localparam logic [1:0] CELL_DONE  = 2'd2;

	// sequencer phase, one-hot
	typedef struct packed {
		logic idle;
		logic rd;
		logic adv;
		logic fin;
	} seq_ctl_t;

endpackage

// ===== sv/pct_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, one write port, one registered read port.
module pct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/pct_cell.sv =====
`timescale 1ns / 1ps

// Pair advance unit: picks one cell out of a progress row, steps it and
// rebuilds the row for write-back.
module pct_cell import pct_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	localparam int IW = $clog2(MAX_POINTS)
) (
	input  logic [MAX_POINTS-1:0]   reach_row,
	input  logic                    reach_ok,
	input  logic [2*MAX_POINTS-1:0] prog_row,
	input  logic                    prog_ok,
	input  logic [IW-1:0]           hi,
	output logic                    reachable,
	output logic                    done_now,
	output logic [2*MAX_POINTS-1:0] new_row
);

	logic [2*MAX_POINTS-1:0] base;
	logic [1:0]              code;
	logic [1:0]              nxt;

	always_comb begin
		// a row never written since reset or clear reads as all blank
		base = prog_ok ? prog_row : '0;
		code = base[{hi, 1'b0} +: 2];
		case (code)
			CELL_BLANK: nxt = CELL_HALF;
			CELL_HALF:  nxt = CELL_DONE;
			default:    nxt = code;
		endcase
		reachable = reach_ok && reach_row[hi];
		done_now  = reachable && (code == CELL_HALF);
		new_row   = base;
		new_row[{hi, 1'b0} +: 2] = nxt;
	end

endmodule

// ===== sv/pct_seq.sv =====
`timescale 1ns / 1ps

// Walk sequencer: read / advance cadence over the partners of a marked point.
module pct_seq import pct_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	localparam int IW = $clog2(MAX_POINTS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [IW-1:0]    p_in,
	input  logic [CFG_W-1:0] n_eff,
	input  logic             adv_ok,
	input  logic             fin_ok,
	output seq_ctl_t         ctl,
	output logic [IW-1:0]    p,
	output logic [IW-1:0]    q,
	output logic [IW-1:0]    lo,
	output logic [IW-1:0]    hi
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_ADV  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]    state_q;
	logic [IW-1:0] p_q;
	logic [IW-1:0] q_q;
	logic          above_q;
	logic          has_above;
	logic          end_above;
	logic          end_below;

	assign has_above = (CFG_W'(p_in) + CFG_W'(1)) < n_eff;
	assign end_above = {1'b0, q_q} == ({1'b0, p_q} + 1'b1);
	assign end_below = ({1'b0, q_q} + 1'b1) == {1'b0, p_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			p_q     <= '0;
			q_q     <= '0;
			above_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						p_q <= p_in;
						if (has_above) begin
							above_q <= 1'b1;
							q_q     <= IW'(n_eff - CFG_W'(1));
							state_q <= S_RD;
						end else if (p_in != '0) begin
							above_q <= 1'b0;
							q_q     <= '0;
							state_q <= S_RD;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_RD: begin
					state_q <= S_ADV;
				end
				S_ADV: begin
					if (adv_ok) begin
						if (above_q) begin
							if (end_above) begin
								if (p_q == '0) begin
									state_q <= S_FIN;
								end else begin
									above_q <= 1'b0;
									q_q     <= '0;
									state_q <= S_RD;
								end
							end else begin
								q_q     <= q_q - 1'b1;
								state_q <= S_RD;
							end
						end else begin
							if (end_below) begin
								state_q <= S_FIN;
							end else begin
								q_q     <= q_q + 1'b1;
								state_q <= S_RD;
							end
						end
					end
				end
				S_FIN: begin
					if (fin_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign ctl.idle = (state_q == S_IDLE);
	assign ctl.rd   = (state_q == S_RD);
	assign ctl.adv  = (state_q == S_ADV);
	assign ctl.fin  = (state_q == S_FIN);

	assign p  = p_q;
	assign q  = q_q;
	assign lo = above_q ? p_q : q_q;
	assign hi = above_q ? q_q : p_q;

endmodule

// ===== sv/pair_completion_tracker.sv =====
`timescale 1ns / 1ps

// Pair completion tracker.
// Input channel (in_valid / in_stall): one request item per handshake.
//   Load and clear-progress requests finish in the accept cycle; the block
//   is ready again on the next cycle.
//   A mark walks the partners of the point; for each partner it reads a
//   progress row, then advances the pair and writes the row back. The
//   read-modify-write of one progress row per partner paces the walk.
// Output channel (out_valid / out_stall): one item per pair that became
//   completed, partners above the point from the top down, then partners
//   below from 0 up; last_of_run flags the final item of a mark, presented
//   when the walk has reached its finish state. One result is held back in
//   a pending register until the next one (or the end of the walk) tells
//   whether it is the last. A stalled output holds the walk when a completion
//   is found while both registers are full, and holds the end of the walk
//   until the pending item can move.
// Config channel (cfg_valid / cfg_ready): writes num_points; always ready.
//   Write it only while the block is idle.
// Reset: asynchronous, active low. All rows read as unreachable, blank,
//   tag zero via per-row valid bits; no clearing pass is needed.
module pair_completion_tracker import pct_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int TAG_BITS   = DEF_TAG_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// config
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_W-1:0]      cfg_num_points,
	// requests
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [POINT_W-1:0]    point_index,
	input  logic [MASK_W-1:0]     reach_mask,
	input  logic [TAG_PORT_W-1:0] result_tag,
	// completed pairs
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [POINT_W-1:0]    first_point,
	output logic [POINT_W-1:0]    second_point,
	output logic [TAG_PORT_W-1:0] first_tag,
	output logic [TAG_PORT_W-1:0] second_tag,
	output logic                  last_of_run
);

	localparam int IW    = $clog2(MAX_POINTS);
	localparam int TAG_W = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;
	localparam int ROW_W = 2 * MAX_POINTS;

	// --- config ---
	logic [CFG_W-1:0] num_points_q;
	logic [CFG_W-1:0] n_eff;

	assign cfg_ready = 1'b1;
	assign n_eff = (num_points_q > CFG_W'(MAX_POINTS)) ? CFG_W'(MAX_POINTS) : num_points_q;

	// --- request decode ---
	seq_ctl_t      ctl;
	logic          acc;
	logic          p_ok;
	logic          req_load;
	logic          req_clr;
	logic          req_mark;
	logic [IW-1:0] p_idx;

	assign in_stall = !ctl.idle;
	assign acc      = in_valid && !in_stall;
	// points at or beyond the count in use are ignored
	assign p_ok     = CFG_W'(point_index) < n_eff;
	assign p_idx    = point_index[IW-1:0];
	assign req_load = acc && (req_type == REQ_LOAD) && p_ok;
	assign req_clr  = acc && (req_type == REQ_CLEAR);
	assign req_mark = acc && (req_type == REQ_MARK) && p_ok;

	// --- sequencer ---
	logic [IW-1:0] seq_p;
	logic [IW-1:0] seq_q;
	logic [IW-1:0] lo;
	logic [IW-1:0] hi;
	logic          adv_ok;
	logic          fin_ok;

	pct_seq #(.MAX_POINTS(MAX_POINTS)) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (req_mark),
		.p_in   (p_idx),
		.n_eff  (n_eff),
		.adv_ok (adv_ok),
		.fin_ok (fin_ok),
		.ctl    (ctl),
		.p      (seq_p),
		.q      (seq_q),
		.lo     (lo),
		.hi     (hi)
	);

	// --- memories, per-row valid bits stand in for the reset contents ---
	logic [MAX_POINTS-1:0] reach_vld_q;
	logic [MAX_POINTS-1:0] prog_vld_q;
	logic [MAX_POINTS-1:0] tag_vld_q;
	logic [MAX_POINTS-1:0] reach_rd;
	logic [ROW_W-1:0]      prog_rd;
	logic [TAG_W-1:0]      tag_rd;
	logic [ROW_W-1:0]      new_row;
	logic                  prog_we;
	logic                  reachable;
	logic                  done_now;

	pct_ram #(.WIDTH(MAX_POINTS), .DEPTH(MAX_POINTS)) u_reach_ram (
		.clk   (clk),
		.we    (req_load),
		.waddr (p_idx),
		.wdata (reach_mask[MAX_POINTS-1:0]),
		.re    (ctl.rd),
		.raddr (lo),
		.rdata (reach_rd)
	);

	pct_ram #(.WIDTH(ROW_W), .DEPTH(MAX_POINTS)) u_prog_ram (
		.clk   (clk),
		.we    (prog_we),
		.waddr (lo),
		.wdata (new_row),
		.re    (ctl.rd),
		.raddr (lo),
		.rdata (prog_rd)
	);

	pct_ram #(.WIDTH(TAG_W), .DEPTH(MAX_POINTS)) u_tag_ram (
		.clk   (clk),
		.we    (req_mark),
		.waddr (p_idx),
		.wdata (result_tag[TAG_W-1:0]),
		.re    (ctl.rd),
		.raddr (seq_q),
		.rdata (tag_rd)
	);

	// pair (lo, hi) lives in row lo, cell hi
	pct_cell #(.MAX_POINTS(MAX_POINTS)) u_cell (
		.reach_row (reach_rd),
		.reach_ok  (reach_vld_q[lo]),
		.prog_row  (prog_rd),
		.prog_ok   (prog_vld_q[lo]),
		.hi        (hi),
		.reachable (reachable),
		.done_now  (done_now),
		.new_row   (new_row)
	);

	// --- result buffering: pending slot plus output register ---
	logic             out_valid_q;
	logic             pend_vld_q;
	logic             out_free;
	logic             push_new;
	logic             move_mid;
	logic             move_last;
	logic [TAG_W-1:0] my_tag_q;
	logic [TAG_W-1:0] partner_tag;
	logic [IW-1:0]    pend_second_q;
	logic [TAG_W-1:0] pend_tag2_q;
	logic [IW-1:0]    out_first_q;
	logic [IW-1:0]    out_second_q;
	logic [TAG_W-1:0] out_tag1_q;
	logic [TAG_W-1:0] out_tag2_q;
	logic             out_last_q;

	assign out_free    = !out_valid_q || !out_stall;
	// hold the walk only if a new completion has nowhere to go
	assign adv_ok      = !(done_now && pend_vld_q && !out_free);
	assign fin_ok      = !pend_vld_q || out_free;
	assign prog_we     = ctl.adv && adv_ok && reachable;
	assign push_new    = ctl.adv && adv_ok && done_now;
	assign move_mid    = push_new && pend_vld_q;
	assign move_last   = ctl.fin && pend_vld_q && out_free;
	// a partner never marked shows tag zero
	assign partner_tag = tag_vld_q[seq_q] ? tag_rd : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_points_q <= CFG_NUM_POINTS_RST;
			reach_vld_q  <= '0;
			prog_vld_q   <= '0;
			tag_vld_q    <= '0;
			pend_vld_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				num_points_q <= cfg_num_points;
			end
			if (req_clr) begin
				prog_vld_q <= '0;
			end
			// a load returns the row's pairs to blank
			if (req_load) begin
				reach_vld_q[p_idx] <= 1'b1;
				prog_vld_q[p_idx]  <= 1'b0;
			end
			if (req_mark) begin
				tag_vld_q[p_idx] <= 1'b1;
			end
			if (prog_we) begin
				prog_vld_q[lo] <= 1'b1;
			end

			if (push_new) begin
				pend_vld_q <= 1'b1;
			end else if (move_last) begin
				pend_vld_q <= 1'b0;
			end

			if (move_mid || move_last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_mark) begin
			my_tag_q <= result_tag[TAG_W-1:0];
		end
		if (push_new) begin
			pend_second_q <= seq_q;
			pend_tag2_q   <= partner_tag;
		end
		if (move_mid || move_last) begin
			out_first_q  <= seq_p;
			out_second_q <= pend_second_q;
			out_tag1_q   <= my_tag_q;
			out_tag2_q   <= pend_tag2_q;
			out_last_q   <= move_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign first_point  = POINT_W'(out_first_q);
	assign second_point = POINT_W'(out_second_q);
	assign first_tag    = TAG_PORT_W'(out_tag1_q);
	assign second_tag   = TAG_PORT_W'(out_tag2_q);
	assign last_of_run  = out_last_q;

	// --- checks ---
	a_pend_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.idle |-> !pend_vld_q)
		else $error("pending result left behind when walk ended");

	a_mark_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_mark |=> in_stall)
		else $error("accepted mark did not start a walk");

	a_pend_from_adv: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pend_vld_q) |-> $past(ctl.adv))
		else $error("pending result loaded outside advance step");

	a_out_from_pend: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pend_vld_q))
		else $error("output item appeared without a pending result");

endmodule
